FILE: rtl/polyev_pkg.sv
package polyev_pkg;

   // sizes
   localparam int MAX_TERMS   = 7;
   localparam int POINT_W     = 16;
   localparam int COEF_W      = 16;
   localparam int VALUE_W     = 32;
   localparam int TERM_W      = 3;
   localparam int CSR_INDEX_W = 4;
   localparam int COEF_SEL_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

   // fixed point: Q8.8 coefficient to Q16.16, Q4.12 point
   localparam int COEF_SHIFT  = 8;
   localparam int FRAC_SHIFT  = 12;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_TERM_COUNT  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FACTOR_BASE = CSR_INDEX_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic single_term;
      logic last_step;
   } status_type;

endpackage

FILE: rtl/polyev_ctrl.sv
module polyev_ctrl import polyev_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output slot is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = status.single_term ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (status.last_step) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/polyev_dp.sv
module polyev_dp import polyev_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [COEF_W-1:0]         csr_data,
   input  logic signed [POINT_W-1:0] point,
   input  cmd_type                   cmd,
   output status_type                status,
   output logic signed [VALUE_W-1:0] value,
   output logic                      overflow
);

   localparam int PROD_W = VALUE_W + POINT_W;
   localparam int RND_W  = PROD_W + 1;
   localparam int SHIFT_W = RND_W - FRAC_SHIFT;
   localparam int SUM_W  = SHIFT_W + 1;
   localparam logic signed [RND_W-1:0] ROUND_BIAS = RND_W'(1) <<< (FRAC_SHIFT - 1);
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   logic [TERM_W-1:0]         term_count_ff;
   logic signed [COEF_W-1:0]  factor_ff [MAX_TERMS];
   logic signed [POINT_W-1:0] x_ff;
   logic signed [VALUE_W-1:0] acc_ff, acc_in;
   logic                      ovf_ff, ovf_in;
   logic [COEF_SEL_W-1:0]     idx_ff, idx_in;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_ovf_ff;

   logic [COEF_SEL_W-1:0]     top_sel, coef_sel;
   logic signed [COEF_W-1:0]  coef;
   logic signed [VALUE_W-1:0] coef_wide;
   logic signed [PROD_W-1:0]  prod;
   logic signed [RND_W-1:0]   rnd_sum;
   logic signed [SHIFT_W-1:0] shifted;
   logic signed [SUM_W-1:0]   next_sum;
   logic                      sat;
   logic signed [VALUE_W-1:0] clamped;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= TERM_W'(1);
         for (int i = 0; i < MAX_TERMS; i++) begin
            factor_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_TERM_COUNT) begin
            term_count_ff <= csr_data[TERM_W-1:0];
         end else if (csr_index >= REG_FACTOR_BASE &&
                      int'(csr_index) < int'(REG_FACTOR_BASE) + MAX_TERMS) begin
            factor_ff[COEF_SEL_W'(csr_index - REG_FACTOR_BASE)] <= csr_data;
         end
      end
   end

   // index of the highest coefficient in use, zero and oversize counts clamped
   always_comb begin
      if (term_count_ff == '0) begin
         top_sel = '0;
      end else if (int'(term_count_ff) > MAX_TERMS) begin
         top_sel = COEF_SEL_W'(MAX_TERMS - 1);
      end else begin
         top_sel = COEF_SEL_W'(term_count_ff - TERM_W'(1));
      end
   end

   // single coefficient read port, Q8.8 sign extended to Q16.16
   assign coef_sel  = cmd.load ? top_sel : idx_ff - COEF_SEL_W'(1);
   assign coef      = factor_ff[coef_sel];
   assign coef_wide = VALUE_W'($signed({coef, {COEF_SHIFT{1'b0}}}));

   // horner step: acc * x, round to nearest, add coefficient, saturate
   assign prod     = PROD_W'(acc_ff) * PROD_W'(x_ff);
   assign rnd_sum  = RND_W'(prod) + ROUND_BIAS;
   assign shifted  = SHIFT_W'(rnd_sum >>> FRAC_SHIFT);
   assign next_sum = SUM_W'(shifted) + SUM_W'(coef_wide);
   assign sat      = !((&next_sum[SUM_W-1:VALUE_W-1]) || !(|next_sum[SUM_W-1:VALUE_W-1]));
   assign clamped  = sat ? (next_sum[SUM_W-1] ? VALUE_MIN : VALUE_MAX)
                         : next_sum[VALUE_W-1:0];

   // working register updates
   always_comb begin
      acc_in = acc_ff;
      ovf_in = ovf_ff;
      idx_in = idx_ff;
      if (cmd.load) begin
         acc_in = coef_wide;
         ovf_in = 1'b0;
         idx_in = top_sel;
      end else if (cmd.step) begin
         acc_in = clamped;
         ovf_in = ovf_ff || sat;
         idx_in = idx_ff - COEF_SEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      ovf_ff <= ovf_in;
      if (cmd.load) begin
         x_ff <= point;
      end
      if (cmd.emit) begin
         rsp_value_ff <= acc_ff;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign status.single_term = (top_sel == '0);
   assign status.last_step   = (idx_ff == COEF_SEL_W'(1));
   assign value              = rsp_value_ff;
   assign overflow           = rsp_ovf_ff;

endmodule

FILE: rtl/polynomial_evaluator.sv
// Polynomial evaluator, Horner's rule, fixed point.
// req channel: one beat carries the point x (signed Q4.12) in req_tdata.
// rsp channel: one beat per request, value (signed Q16.16, saturated) in
//    rsp_tdata and the overflow flag in rsp_tuser.
// csr channel: register 0 is the term count (1..7, zero reads as one),
//    registers 1..7 are the coefficients of x^0..x^6 (signed Q8.8);
//    csr_ready is always high, indexes above 7 are dropped; write only idle.
// Timing: the accepting edge loads the top coefficient, then the shared
//    multiply-add unit takes a step for each extra term, then the sum
//    moves into the output register; rsp_tvalid rises and req_tready
//    returns in the same cycle, so a new request is taken only once
//    the previous result sits in the output register.
// Stall: the output register holds one result; while it waits, one more
//    request is taken and evaluated, then the block holds it until the
//    output register frees and keeps req_tready low meanwhile.
// Reset: synchronous, active high; term count returns to one, all
//    coefficients to zero, both channels empty.
module polynomial_evaluator import polyev_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [POINT_W-1:0]     req_tdata,   // [15:0] point
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [VALUE_W-1:0]     rsp_tdata,   // [31:0] value
   output logic                   rsp_tuser,   // [0] overflow
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]      csr_data
);

   cmd_type                   cmd;
   status_type                status;
   logic signed [VALUE_W-1:0] value;

   assign csr_ready = 1'b1;

   polyev_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   polyev_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .point     (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .value     (value),
      .overflow  (rsp_tuser)
   );

   assign rsp_tdata = value;

   // one item in flight: an accepted beat blocks the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an evaluation is in flight");

   // a new result lands only as the controller returns to idle
   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result loaded outside the return to idle");

   // load and step, or step and emit, never issued together
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.step) && !(cmd.step && cmd.emit))
      else $error("conflicting datapath commands");

endmodule

FILE: tb/sv/poly_result_checker.sv
`timescale 1ns / 1ps
module poly_result_checker
   import polyev_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [POINT_W-1:0]     req_tdata,   // [15:0] point
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [VALUE_W-1:0]     rsp_tdata,   // [31:0] value
   input  logic                   rsp_tuser,   // [0] overflow
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]      csr_data,
   output int                     mismatches,
   output int                     pending
);

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               overflow;
   } poly_result_t;

   localparam longint VALUE_MAX = 64'sd2147483647;
   localparam longint VALUE_MIN = -64'sd2147483648;

   // shadow copy of the register file
   logic [TERM_W-1:0] term_count;
   logic [COEF_W-1:0] coef [MAX_TERMS];

   poly_result_t expected_q [$];

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   // horner evaluation with per-step rounding and saturation
   function automatic poly_result_t horner_eval(input logic [POINT_W-1:0] point);
      longint       x;
      longint       acc;
      longint       prod;
      longint       sum;
      int           n;
      poly_result_t r;
      x = longint'($signed(point));
      n = (term_count == '0) ? 1 : int'(term_count);
      if (n > MAX_TERMS) n = MAX_TERMS;
      r.overflow = 1'b0;
      acc = longint'($signed(coef[n-1])) * (longint'(1) << COEF_SHIFT);
      for (int i = n - 2; i >= 0; i--) begin
         prod = acc * x;
         // round to nearest, ties toward plus infinity
         sum = ((prod + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT)
               + longint'($signed(coef[i])) * (longint'(1) << COEF_SHIFT);
         if (sum > VALUE_MAX) begin
            sum = VALUE_MAX;
            r.overflow = 1'b1;
         end else if (sum < VALUE_MIN) begin
            sum = VALUE_MIN;
            r.overflow = 1'b1;
         end
         acc = sum;
      end
      r.value = acc[VALUE_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] want);
      $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
      mismatches = mismatches + 1;
   endtask

   // track register writes, predict on request beats, compare response beats
   always @(posedge clock) begin
      poly_result_t want;
      if (reset) begin
         term_count = TERM_W'(1);
         for (int k = 0; k < MAX_TERMS; k++) coef[k] = '0;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_TERM_COUNT) begin
               term_count = csr_data[TERM_W-1:0];
            end else if (int'(csr_index) < int'(REG_FACTOR_BASE) + MAX_TERMS) begin
               coef[int'(csr_index) - int'(REG_FACTOR_BASE)] = csr_data;
            end
         end
         if (req_tvalid && req_tready) begin
            expected_q.push_back(horner_eval(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata, '0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata !== want.value)
                  report_mismatch("value", rsp_tdata, want.value);
               if (rsp_tuser !== want.overflow)
                  report_mismatch("overflow", VALUE_W'(rsp_tuser), VALUE_W'(want.overflow));
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import polyev_pkg::*;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_t;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_FIRST =
      CSR_INDEX_W'(int'(REG_FACTOR_BASE) + MAX_TERMS);

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [POINT_W-1:0]     req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [VALUE_W-1:0]     rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [COEF_W-1:0]      csr_data   = '0;
   int                     mismatches;
   int                     pending;

   int send_idle_pct = 0;
   int stall_pct     = 0;

   polynomial_evaluator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   poly_result_checker result_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // random back-pressure on the response side
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic set_idling(input idle_mode_t mode);
      send_idle_pct = (mode == IDLE_SENDER) ? 74 : (mode == IDLE_BOTH) ? 35 : 0;
      stall_pct     = (mode == IDLE_RECEIVER) ? 74 : (mode == IDLE_BOTH) ? 35 : 0;
   endtask

   // one register write beat
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [COEF_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_all_coefs(input logic [COEF_W-1:0] data);
      for (int k = 0; k < MAX_TERMS; k++)
         write_reg(CSR_INDEX_W'(int'(REG_FACTOR_BASE) + k), data);
   endtask

   // one request beat, with random idle cycles ahead of it
   task automatic send_point(input logic [POINT_W-1:0] x);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending and wait until every predicted result has come back
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   function automatic logic [COEF_W-1:0] choose_coef();
      case ($urandom_range(3))
         0: return COEF_W'($urandom);
         1: begin
            if ($urandom_range(2) == 0) return '0;
            return ($urandom_range(1) != 0) ? 16'h7fff : 16'h8000;
         end
         default: return COEF_W'($urandom_range(1023)) - 16'd512;
      endcase
   endfunction

   function automatic logic [POINT_W-1:0] choose_point();
      case ($urandom_range(3))
         0: return POINT_W'($urandom);
         1: return POINT_W'($urandom_range(8191)) - 16'd4096;
         2: return ($urandom_range(1) != 0) ? 16'h7fff : 16'h8000;
         default: return POINT_W'($urandom_range(16383)) - 16'd8192;
      endcase
   endfunction

   // run limit
   initial begin
      #(5_000_000);
      $display("FAIL polynomial_evaluator");
      $finish;
   end

   initial begin
      logic [TERM_W-1:0] terms;
      set_idling(IDLE_NONE);
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset settings: one term, zero coefficients
      send_point(16'h0000);
      send_point(16'h7fff);
      send_point(16'h8000);

      // term count zero acts as one, so only the constant term shows
      drain_results();
      write_reg(REG_TERM_COUNT, 16'h0000);
      write_reg(REG_FACTOR_BASE, 16'h8000);
      send_point(16'h1234);

      // all seven terms at the positive extreme, saturation both ways
      drain_results();
      write_reg(REG_TERM_COUNT, 16'h0007);
      write_all_coefs(16'h7fff);
      send_point(16'h7fff);
      send_point(16'h8000);
      send_point(16'h0000);
      send_point(16'h0001);
      send_point(16'hffff);
      send_point(16'h1000);

      // all seven terms at the negative extreme
      drain_results();
      write_all_coefs(16'h8000);
      send_point(16'h7fff);
      send_point(16'h8000);
      send_point(16'h1000);
      send_point(16'hf000);

      // rounding: ties go toward plus infinity; unused indexes are dropped
      drain_results();
      write_reg(REG_TERM_COUNT, 16'hfffa);
      write_reg(REG_FACTOR_BASE, 16'h0000);
      write_reg(CSR_INDEX_W'(int'(REG_FACTOR_BASE) + 1), 16'h0001);
      write_reg(REG_UNUSED_FIRST, 16'hffff);
      write_reg(CSR_INDEX_W'('1), 16'h5a5a);
      send_point(16'hffff);
      send_point(16'h0008);
      send_point(16'hfff8);
      send_point(16'hfff7);
      send_point(16'h0007);

      // random phases, each with its own settings and idling pattern
      for (int phase = 0; phase < 8; phase++) begin
         drain_results();
         if (phase == 0) terms = 3'd7;
         else if (phase == 1) terms = 3'd1;
         else terms = TERM_W'($urandom_range(7));
         write_reg(REG_TERM_COUNT, {13'($urandom), terms});
         for (int k = 0; k < MAX_TERMS; k++)
            write_reg(CSR_INDEX_W'(int'(REG_FACTOR_BASE) + k), choose_coef());
         if ($urandom_range(1) != 0)
            write_reg(CSR_INDEX_W'($urandom_range(15, int'(REG_UNUSED_FIRST))),
                      COEF_W'($urandom));
         set_idling(idle_mode_t'(phase % 4));
         repeat (130) begin
            if ($urandom_range(99) == 0) drain_results();
            send_point(choose_point());
         end
      end

      drain_results();
      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("PASS polynomial_evaluator");
      end else begin
         $display("FAIL polynomial_evaluator");
      end
      $finish;
   end

endmodule
